// ----- rtl/pdhb_pkg.sv -----
// Shared types, constants and tables of the polar depth histogram builder.
// Used by pdhb_cordic, polar_depth_histogram_builder and the testbench; depends on nothing.

package pdhb_pkg;

    // Default parameter values.
    localparam int SECTOR_COUNT_DEF = 45;
    localparam int KEEP_NEAREST_DEF = 10;

    // Field and datapath widths.
    localparam int COORD_W      = 16;
    localparam int SECT_W       = 6;
    localparam int DIST_W       = 16;
    localparam int FOV_W        = 18;
    localparam int SPR_W        = 24;
    localparam int ANG_W        = 20;
    localparam int CORD_W       = 34;
    localparam int CORD_SHIFT   = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int SQ_W         = 32;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;

    // Register reset values.
    localparam logic [FOV_W-1:0] RESET_H_FOV = 18'd98368;
    localparam logic [FOV_W-1:0] RESET_V_FOV = 18'd53462;
    localparam logic [SPR_W-1:0] RESET_H_SPR = 24'd1964792;
    localparam logic [SPR_W-1:0] RESET_V_SPR = 24'd3615164;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_H_FOV = 2'd0,
        CFG_V_FOV = 2'd1,
        CFG_H_SPR = 2'd2,
        CFG_V_SPR = 2'd3
    } cfg_index_t;

    // Item kinds.
    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Arctangent of 2^-i in Q2.16 radians, rounded to nearest except for i = 1, which is rounded down.
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        begin
            unique case (i)
                4'd0:    v = 20'sd51472;
                4'd1:    v = 20'sd30385;
                4'd2:    v = 20'sd16055;
                4'd3:    v = 20'sd8150;
                4'd4:    v = 20'sd4091;
                4'd5:    v = 20'sd2047;
                4'd6:    v = 20'sd1024;
                4'd7:    v = 20'sd512;
                4'd8:    v = 20'sd256;
                4'd9:    v = 20'sd128;
                4'd10:   v = 20'sd64;
                4'd11:   v = 20'sd32;
                4'd12:   v = 20'sd16;
                4'd13:   v = 20'sd8;
                4'd14:   v = 20'sd4;
                default: v = 20'sd2;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/pdhb_cordic.sv -----
// Iterative vectoring CORDIC: atan2(num, den) in signed Q2.16 radians.
// One micro-rotation per cycle; depends on pdhb_pkg.

module pdhb_cordic
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [pdhb_pkg::COORD_W-1:0]   num,
    input  logic signed [pdhb_pkg::COORD_W-1:0]   den,
    output logic                                  done,
    output logic signed [pdhb_pkg::ANG_W-1:0]     angle
);

    logic signed [pdhb_pkg::CORD_W-1:0] x_reg;
    logic signed [pdhb_pkg::CORD_W-1:0] y_reg;
    logic signed [pdhb_pkg::ANG_W-1:0]  acc_reg;
    logic [pdhb_pkg::STEP_W-1:0]        step_reg;
    logic                               busy_reg;
    logic                               done_reg;

    logic signed [pdhb_pkg::CORD_W-1:0] num_ext;
    logic signed [pdhb_pkg::CORD_W-1:0] den_ext;
    logic signed [pdhb_pkg::CORD_W-1:0] x_sh;
    logic signed [pdhb_pkg::CORD_W-1:0] y_sh;
    logic                               both_zero;

    // Operands scaled into the rotation word.
    assign num_ext = {{(pdhb_pkg::CORD_W - pdhb_pkg::COORD_W - pdhb_pkg::CORD_SHIFT){num[15]}},
                      num, {pdhb_pkg::CORD_SHIFT{1'b0}}};
    assign den_ext = {{(pdhb_pkg::CORD_W - pdhb_pkg::COORD_W - pdhb_pkg::CORD_SHIFT){den[15]}},
                      den, {pdhb_pkg::CORD_SHIFT{1'b0}}};
    assign both_zero = (num == '0) && (den == '0);

    assign x_sh = x_reg >>> step_reg;
    assign y_sh = y_reg >>> step_reg;

    // Pre-rotation into the right half plane, then one step per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                if (both_zero)
                begin
                    acc_reg  <= '0;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    if (den_ext < 0)
                    begin
                        if (num_ext >= 0)
                        begin
                            x_reg   <= num_ext;
                            y_reg   <= -den_ext;
                            acc_reg <= pdhb_pkg::HALF_PI_Q16;
                        end
                        else
                        begin
                            x_reg   <= -num_ext;
                            y_reg   <= den_ext;
                            acc_reg <= -pdhb_pkg::HALF_PI_Q16;
                        end
                    end
                    else
                    begin
                        x_reg   <= den_ext;
                        y_reg   <= num_ext;
                        acc_reg <= '0;
                    end
                end
            end
            else if (busy_reg)
            begin
                if (y_reg >= 0)
                begin
                    x_reg   <= x_reg + y_sh;
                    y_reg   <= y_reg - x_sh;
                    acc_reg <= acc_reg + pdhb_pkg::atan_entry(step_reg);
                end
                else
                begin
                    x_reg   <= x_reg - y_sh;
                    y_reg   <= y_reg + x_sh;
                    acc_reg <= acc_reg - pdhb_pkg::atan_entry(step_reg);
                end
                step_reg <= step_reg + 1'b1;
                if (step_reg == pdhb_pkg::STEP_W'(pdhb_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign angle = acc_reg;

endmodule

// ----- rtl/polar_depth_histogram_builder.sv -----
// Polar depth histogram builder: top level with sequencer, shared multiplier,
// square root, divider and bin memories; depends on pdhb_pkg and pdhb_cordic.
//
//  channel  direction  tdata / data                       tuser
//  s_*      in         x, y, z, query_h, query_v (64 b)   kind, new_frame
//  m_*      out        mean_distance_mm, samples_used     bin_empty
//  cfg_*    in         register index, write data         -
//
// A kept point passes through two CORDIC runs on the one rotation unit (with the sector
// product), three squares, a 16-step root, a count read and a sorted insert.
// Dropped points and points with two zero operands for an angle take fewer cycles.
// A new frame first runs the fill-count clearing sweep over all SECTOR_COUNT^2 bins,
// and the same sweep runs after reset before the first item is taken.
// A query reads the fill count, sums the kept distances and rounds the mean with
// a 20-step divide; an empty bin skips the sum and the divide.
// A result waits in the output register; the next query stalls in its last state
// until m_tready frees that register.

module polar_depth_histogram_builder
#(
    parameter int SECTOR_COUNT = pdhb_pkg::SECTOR_COUNT_DEF,
    parameter int KEEP_NEAREST = pdhb_pkg::KEEP_NEAREST_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_mm, y_mm, z_mm, query_h_sector, query_v_sector, 0 pad
    input  logic [1:0]  s_tuser,   // kind, new_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // mean_distance_mm, samples_used, 0 pad
    output logic        m_tuser,   // bin_empty
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int NBINS  = SECTOR_COUNT * SECTOR_COUNT;
    localparam int BIN_W  = (NBINS > 1) ? $clog2(NBINS) : 1;
    localparam int DEPTH  = NBINS * KEEP_NEAREST;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(KEEP_NEAREST + 1);
    localparam int SUM_W  = pdhb_pkg::DIST_W + CNT_W;
    localparam int DIVC_W = $clog2(SUM_W);
    localparam int MA_W   = pdhb_pkg::FOV_W + 1;
    localparam int PROD_W = MA_W + pdhb_pkg::SPR_W;
    localparam int K_W    = PROD_W - 32;
    localparam int A2_W   = pdhb_pkg::ANG_W + 1;

    typedef enum logic [20:0] {
        S_INIT    = 21'h000001,
        S_IDLE    = 21'h000002,
        S_CLEAR   = 21'h000004,
        S_ATG     = 21'h000008,
        S_ATW     = 21'h000010,
        S_FOV     = 21'h000020,
        S_IDX     = 21'h000040,
        S_SQ      = 21'h000080,
        S_SQRT    = 21'h000100,
        S_CNT_RD  = 21'h000200,
        S_CNT     = 21'h000400,
        S_FULL    = 21'h000800,
        S_SH_RD   = 21'h001000,
        S_SH_CMP  = 21'h002000,
        S_QBIN    = 21'h004000,
        S_QCNT_RD = 21'h008000,
        S_QCNT    = 21'h010000,
        S_QRD     = 21'h020000,
        S_QACC    = 21'h040000,
        S_DIV     = 21'h080000,
        S_RES     = 21'h100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [pdhb_pkg::FOV_W-1:0] h_fov_reg, v_fov_reg;
    logic [pdhb_pkg::SPR_W-1:0] h_spr_reg, v_spr_reg;

    // Item payload.
    logic signed [pdhb_pkg::COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [pdhb_pkg::SECT_W-1:0]         qh_reg, qv_reg;

    // Sequencer datapath.
    logic                              sel_reg;
    logic [BIN_W-1:0]                  clr_reg;
    logic signed [pdhb_pkg::ANG_W-1:0] ang_reg;
    logic [PROD_W-1:0]                 prod_reg;
    logic [pdhb_pkg::SECT_W-1:0]       hi_reg;
    logic [BIN_W-1:0]                  bin_reg;
    logic [ADDR_W-1:0]                 row_base_reg;
    logic [1:0]                        sq_cnt_reg;
    logic [pdhb_pkg::SQ_W-1:0]         sq_src_reg;
    logic [pdhb_pkg::DIST_W+1:0]       sq_rem_reg;
    logic [pdhb_pkg::DIST_W-1:0]       root_reg;
    logic [pdhb_pkg::STEP_W-1:0]       it_reg;
    logic [pdhb_pkg::DIST_W-1:0]       d_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [CNT_W-1:0]                  p_reg;
    logic [CNT_W-1:0]                  n_reg;
    logic [CNT_W-1:0]                  idx_reg;
    logic [SUM_W-1:0]                  sum_reg;
    logic [SUM_W-1:0]                  div_num_reg;
    logic [CNT_W-1:0]                  div_rem_reg;
    logic [DIVC_W-1:0]                 div_cnt_reg;
    logic                              res_empty_reg;

    // Output register.
    logic                        m_tvalid_reg;
    logic [pdhb_pkg::DIST_W-1:0] out_mean_reg;
    logic [4:0]                  out_samples_reg;
    logic                        out_empty_reg;

    // Memories.
    logic [CNT_W-1:0]            cnt_mem [NBINS];
    logic [pdhb_pkg::DIST_W-1:0] dist_mem [DEPTH];
    logic [CNT_W-1:0]            cnt_rdata;
    logic [pdhb_pkg::DIST_W-1:0] dist_rdata;

    logic                        cnt_we;
    logic [BIN_W-1:0]            cnt_waddr;
    logic [CNT_W-1:0]            cnt_wdata;
    logic                        dist_re;
    logic [CNT_W-1:0]            dist_rslot;
    logic                        dist_we;
    logic [CNT_W-1:0]            dist_wslot;
    logic [pdhb_pkg::DIST_W-1:0] dist_wdata;
    logic [ADDR_W-1:0]           dist_raddr, dist_waddr;

    // Combinational helpers.
    logic                               accept;
    logic                               in_kind, in_new_frame;
    logic [pdhb_pkg::SECT_W-1:0]        in_qh, in_qv;
    logic                               q_oor;
    logic                               clr_last;
    logic                               cordic_start, cordic_done;
    logic signed [pdhb_pkg::COORD_W-1:0] cordic_num;
    logic signed [pdhb_pkg::ANG_W-1:0]  cordic_angle;
    logic signed [A2_W-1:0]             a2, fov_s, t_sum;
    logic                               in_fov;
    logic [MA_W-1:0]                    mult_a;
    logic [pdhb_pkg::SPR_W-1:0]         mult_b;
    logic [PROD_W:0]                    k_sum;
    logic [K_W-1:0]                     k_val;
    logic                               k_ok;
    logic [16:0]                        abs_x, abs_y, abs_z;
    logic [pdhb_pkg::DIST_W+3:0]        rem_sh, trial;
    logic                               rt_ge;
    logic [16:0]                        d_round;
    logic                               full;
    logic [SUM_W-1:0]                   acc_sum;
    logic [CNT_W:0]                     div_sh;
    logic                               div_ge;
    logic                               out_load;

    assign in_kind      = s_tuser[0];
    assign in_new_frame = s_tuser[1];
    assign in_qh        = s_tdata[53:48];
    assign in_qv        = s_tdata[59:54];
    assign q_oor        = ({1'b0, in_qh} >= 7'(SECTOR_COUNT)) || ({1'b0, in_qv} >= 7'(SECTOR_COUNT));
    assign s_tready     = (state_reg == S_IDLE);
    assign accept       = s_tvalid && s_tready;
    assign clr_last     = (clr_reg == BIN_W'(NBINS - 1));
    assign out_load     = (state_reg == S_RES) && (!m_tvalid_reg || m_tready);

    // Field of view check and sector offset.
    assign a2     = {ang_reg, 1'b0};
    assign fov_s  = sel_reg ? A2_W'({3'b000, v_fov_reg}) : A2_W'({3'b000, h_fov_reg});
    assign in_fov = (a2 >= -fov_s) && (a2 <= fov_s);
    assign t_sum  = a2 + fov_s;

    // Round half up: (t * spr + 2^32) >> 33.
    assign k_sum = {1'b0, prod_reg} + (PROD_W + 1)'(64'h1_0000_0000);
    assign k_val = k_sum[PROD_W:33];
    assign k_ok  = k_val < K_W'(SECTOR_COUNT);

    // Magnitudes for the squares.
    assign abs_x = x_reg[15] ? 17'(-{x_reg[15], x_reg}) : {1'b0, x_reg};
    assign abs_y = y_reg[15] ? 17'(-{y_reg[15], y_reg}) : {1'b0, y_reg};
    assign abs_z = z_reg[15] ? 17'(-{z_reg[15], z_reg}) : {1'b0, z_reg};

    // Shared multiplier operand selection.
    always_comb
    begin
        mult_a = '0;
        mult_b = '0;
        if (state_reg == S_FOV)
        begin
            mult_a = t_sum[MA_W-1:0];
            mult_b = sel_reg ? v_spr_reg : h_spr_reg;
        end
        else
        begin
            unique case (sq_cnt_reg)
                2'd0:
                begin
                    mult_a = MA_W'(abs_x);
                    mult_b = pdhb_pkg::SPR_W'(abs_x);
                end
                2'd1:
                begin
                    mult_a = MA_W'(abs_y);
                    mult_b = pdhb_pkg::SPR_W'(abs_y);
                end
                2'd2:
                begin
                    mult_a = MA_W'(abs_z);
                    mult_b = pdhb_pkg::SPR_W'(abs_z);
                end
                default:
                begin
                    mult_a = '0;
                    mult_b = '0;
                end
            endcase
        end
    end

    // One root digit per cycle.
    assign rem_sh  = {sq_rem_reg, sq_src_reg[pdhb_pkg::SQ_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign rt_ge   = rem_sh >= trial;
    assign d_round = {1'b0, root_reg} + 17'(sq_rem_reg > {2'b00, root_reg});

    assign full    = cnt_rdata >= CNT_W'(KEEP_NEAREST);
    assign acc_sum = sum_reg + SUM_W'(dist_rdata);

    // One quotient bit per cycle.
    assign div_sh = {div_rem_reg, div_num_reg[SUM_W-1]};
    assign div_ge = div_sh >= {1'b0, n_reg};

    assign cordic_num   = sel_reg ? y_reg : x_reg;
    assign cordic_start = (state_reg == S_ATG);

    pdhb_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .num   (cordic_num),
        .den   (z_reg),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    // Memory port control.
    always_comb
    begin
        cnt_we     = 1'b0;
        cnt_waddr  = bin_reg;
        cnt_wdata  = (cnt_reg < CNT_W'(KEEP_NEAREST)) ? CNT_W'(cnt_reg + 1'b1) : cnt_reg;
        dist_re    = 1'b0;
        dist_rslot = '0;
        dist_we    = 1'b0;
        dist_wslot = p_reg;
        dist_wdata = d_reg;
        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
            end
            S_CNT:
            begin
                dist_re    = 1'b1;
                dist_rslot = CNT_W'(KEEP_NEAREST - 1);
            end
            S_SH_RD:
            begin
                if (p_reg == '0)
                begin
                    dist_we = 1'b1;
                    cnt_we  = 1'b1;
                end
                else
                begin
                    dist_re    = 1'b1;
                    dist_rslot = CNT_W'(p_reg - 1'b1);
                end
            end
            S_SH_CMP:
            begin
                dist_we = 1'b1;
                if (dist_rdata > d_reg)
                begin
                    dist_wdata = dist_rdata;
                end
                else
                begin
                    cnt_we = 1'b1;
                end
            end
            S_QRD:
            begin
                dist_re    = 1'b1;
                dist_rslot = idx_reg;
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    assign dist_raddr = ADDR_W'(row_base_reg + ADDR_W'(dist_rslot));
    assign dist_waddr = ADDR_W'(row_base_reg + ADDR_W'(dist_wslot));

    // Fill-count memory.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[bin_reg];
    end

    // Distance memory, one row of kept distances per bin.
    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        if (dist_re)
        begin
            dist_rdata <= dist_mem[dist_raddr];
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:    if (clr_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == pdhb_pkg::KIND_QUERY)
                        state_next = q_oor ? S_RES : S_QBIN;
                    else
                        state_next = in_new_frame ? S_CLEAR : S_ATG;
                end
            end
            S_CLEAR:   if (clr_last) state_next = S_ATG;
            S_ATG:     state_next = S_ATW;
            S_ATW:     if (cordic_done) state_next = S_FOV;
            S_FOV:     state_next = in_fov ? S_IDX : S_IDLE;
            S_IDX:
            begin
                if (!k_ok)
                    state_next = S_IDLE;
                else
                    state_next = sel_reg ? S_SQ : S_ATG;
            end
            S_SQ:      if (sq_cnt_reg == 2'd3) state_next = S_SQRT;
            S_SQRT:    if (it_reg == '0) state_next = S_CNT_RD;
            S_CNT_RD:  state_next = S_CNT;
            S_CNT:     state_next = full ? S_FULL : S_SH_RD;
            S_FULL:    state_next = (d_reg >= dist_rdata) ? S_IDLE : S_SH_RD;
            S_SH_RD:   state_next = (p_reg == '0) ? S_IDLE : S_SH_CMP;
            S_SH_CMP:  state_next = (dist_rdata > d_reg) ? S_SH_RD : S_IDLE;
            S_QBIN:    state_next = S_QCNT_RD;
            S_QCNT_RD: state_next = S_QCNT;
            S_QCNT:    state_next = (cnt_rdata == '0) ? S_RES : S_QRD;
            S_QRD:     state_next = S_QACC;
            S_QACC:    if (CNT_W'(idx_reg + 1'b1) == n_reg) state_next = S_DIV;
                       else state_next = S_QRD;
            S_DIV:     if (div_cnt_reg == '0) state_next = S_RES;
            S_RES:     if (out_load) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            h_fov_reg    <= pdhb_pkg::RESET_H_FOV;
            v_fov_reg    <= pdhb_pkg::RESET_V_FOV;
            h_spr_reg    <= pdhb_pkg::RESET_H_SPR;
            v_spr_reg    <= pdhb_pkg::RESET_V_SPR;
        end
        else
        begin
            state_reg <= state_next;

            if ((state_reg == S_INIT) || (state_reg == S_CLEAR))
                clr_reg <= clr_last ? '0 : BIN_W'(clr_reg + 1'b1);

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (pdhb_pkg::cfg_index_t'(cfg_index))
                    pdhb_pkg::CFG_H_FOV: h_fov_reg <= cfg_data[pdhb_pkg::FOV_W-1:0];
                    pdhb_pkg::CFG_V_FOV: v_fov_reg <= cfg_data[pdhb_pkg::FOV_W-1:0];
                    pdhb_pkg::CFG_H_SPR: h_spr_reg <= cfg_data;
                    pdhb_pkg::CFG_V_SPR: v_spr_reg <= cfg_data;
                    default:             h_spr_reg <= h_spr_reg;
                endcase
            end
        end
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge clk)
    begin
        prod_reg     <= PROD_W'(mult_a) * PROD_W'(mult_b);
        row_base_reg <= ADDR_W'(17'(bin_reg) * 17'(KEEP_NEAREST));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_reg         <= s_tdata[15:0];
                    y_reg         <= s_tdata[31:16];
                    z_reg         <= s_tdata[47:32];
                    qh_reg        <= in_qh;
                    qv_reg        <= in_qv;
                    sel_reg       <= 1'b0;
                    res_empty_reg <= 1'b1;
                end
            end
            S_ATW:
            begin
                if (cordic_done)
                    ang_reg <= cordic_angle;
            end
            S_IDX:
            begin
                if (!sel_reg)
                begin
                    hi_reg  <= k_val[pdhb_pkg::SECT_W-1:0];
                    sel_reg <= 1'b1;
                end
                else
                begin
                    bin_reg <= BIN_W'(13'(hi_reg) * 13'(SECTOR_COUNT)
                                      + 13'(k_val[pdhb_pkg::SECT_W-1:0]));
                end
                sq_cnt_reg <= '0;
                sq_src_reg <= '0;
            end
            S_SQ:
            begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
                if (sq_cnt_reg != 2'd0)
                    sq_src_reg <= sq_src_reg + prod_reg[pdhb_pkg::SQ_W-1:0];
                sq_rem_reg <= '0;
                root_reg   <= '0;
                it_reg     <= pdhb_pkg::STEP_W'(pdhb_pkg::CORDIC_STEPS - 1);
            end
            S_SQRT:
            begin
                sq_src_reg <= {sq_src_reg[pdhb_pkg::SQ_W-3:0], 2'b00};
                if (rt_ge)
                begin
                    sq_rem_reg <= (pdhb_pkg::DIST_W + 2)'(rem_sh - trial);
                    root_reg   <= {root_reg[pdhb_pkg::DIST_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= rem_sh[pdhb_pkg::DIST_W+1:0];
                    root_reg   <= {root_reg[pdhb_pkg::DIST_W-2:0], 1'b0};
                end
                it_reg <= it_reg - 1'b1;
            end
            S_CNT_RD:
            begin
                d_reg <= d_round[16] ? '1 : d_round[pdhb_pkg::DIST_W-1:0];
            end
            S_CNT:
            begin
                cnt_reg <= cnt_rdata;
                p_reg   <= cnt_rdata;
            end
            S_FULL:
            begin
                p_reg <= CNT_W'(KEEP_NEAREST - 1);
            end
            S_SH_CMP:
            begin
                if (dist_rdata > d_reg)
                    p_reg <= CNT_W'(p_reg - 1'b1);
            end
            S_QBIN:
            begin
                bin_reg <= BIN_W'(13'(qh_reg) * 13'(SECTOR_COUNT) + 13'(qv_reg));
            end
            S_QCNT:
            begin
                n_reg         <= cnt_rdata;
                idx_reg       <= '0;
                sum_reg       <= '0;
                res_empty_reg <= (cnt_rdata == '0);
            end
            S_QACC:
            begin
                sum_reg     <= acc_sum;
                idx_reg     <= CNT_W'(idx_reg + 1'b1);
                div_num_reg <= acc_sum + SUM_W'(n_reg >> 1);
                div_rem_reg <= '0;
                div_cnt_reg <= DIVC_W'(SUM_W - 1);
            end
            S_DIV:
            begin
                div_rem_reg <= div_ge ? CNT_W'(div_sh - {1'b0, n_reg}) : div_sh[CNT_W-1:0];
                div_num_reg <= {div_num_reg[SUM_W-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            default:
            begin
                sel_reg <= sel_reg;
            end
        endcase

        // Result capture into the output register.
        if (out_load)
        begin
            out_empty_reg   <= res_empty_reg;
            out_mean_reg    <= res_empty_reg ? '1 : div_num_reg[pdhb_pkg::DIST_W-1:0];
            out_samples_reg <= res_empty_reg ? 5'd0 : 5'(n_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_samples_reg, out_mean_reg};
    assign m_tuser  = out_empty_reg;

endmodule

// ----- rtl/pdhb_checker.sv -----
// Port-level checks of the polar depth histogram builder, bound to its top level.
// Depends on polar_depth_histogram_builder only through the bind below.

module pdhb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on two cycles in a row");

    // An empty bin reads as the saturated distance with no samples.
    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[15:0] == 16'hFFFF) && (m_tdata[20:16] == 5'd0))
        else $error("empty bin result carries wrong fields");

    // A filled bin always reports at least one sample.
    a_samples: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[20:16] != 5'd0) && (m_tdata[23:21] == 3'd0))
        else $error("non-empty result without samples");

    // A stalled result stays.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind polar_depth_histogram_builder pdhb_checker u_pdhb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- dv/tb.sv -----
// Self-checking testbench of polar_depth_histogram_builder: points and queries go in
// on the input stream and a built-in histogram predictor checks every query result.
// Depends on pdhb_pkg and the block RTL.

module tb;

    localparam int NSECT = pdhb_pkg::SECTOR_COUNT_DEF;
    localparam int KEEP  = pdhb_pkg::KEEP_NEAREST_DEF;
    localparam int NBINS = NSECT * NSECT;

    typedef struct packed {
        logic [15:0] mean_mm;
        logic        empty;
        logic [4:0]  used;
    } bin_reading_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    // Predictor state: registers and bins.
    logic [17:0] h_fov, v_fov;
    logic [23:0] h_spr, v_spr;
    logic [15:0] bin_dist [NBINS][KEEP];
    int          bin_fill [NBINS];

    bin_reading_t expected_readings[$];
    int           error_count;
    bit           idle_enable;
    int           results_seen;

    polar_depth_histogram_builder DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Arithmetic shift right of a signed 64-bit value.
    function automatic longint asr(input longint v, input int s);
        return v >>> s;
    endfunction

    // Fixed-point CORDIC atan2 in Q2.16 radians.
    function automatic int angle_of(input longint num, input longint den);
        longint cx, cy, nx, ny, t;
        int acc;
        int atab[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2};
        cx = den * 16384;
        cy = num * 16384;
        acc = 0;
        if (num == 0 && den == 0)
            return 0;
        if (cx < 0)
        begin
            t = cx;
            if (cy >= 0)
            begin
                cx = cy; cy = -t; acc = 102944;
            end
            else
            begin
                cx = -cy; cy = t; acc = -102944;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            if (cy >= 0)
            begin
                nx = cx + asr(cy, i); ny = cy - asr(cx, i); acc += atab[i];
            end
            else
            begin
                nx = cx - asr(cy, i); ny = cy + asr(cx, i); acc -= atab[i];
            end
            cx = nx; cy = ny;
        end
        return acc;
    endfunction

    // Sector of an angle, or -1 when outside the view or the grid.
    function automatic int sector_of(input int ang, input logic [17:0] fov,
                                     input logic [23:0] spr);
        longint a2;
        longint unsigned t, k;
        a2 = longint'(ang) * 2;
        if (a2 < -longint'(fov) || a2 > longint'(fov))
            return -1;
        t = a2 + longint'(fov);
        k = (t * spr + (64'd1 << 32)) >> 33;
        if (k >= NSECT)
            return -1;
        return int'(k);
    endfunction

    // Euclidean distance rounded to nearest and saturated, digit by digit.
    function automatic logic [15:0] range_of(input longint unsigned s);
        longint unsigned r, v, one_q;
        r = 0;
        v = s;
        one_q = 64'd1 << 62;
        while (one_q > v)
            one_q >>= 2;
        while (one_q != 0)
        begin
            if (v >= r + one_q)
            begin
                v -= r + one_q;
                r = (r >> 1) + one_q;
            end
            else
            begin
                r >>= 1;
            end
            one_q >>= 2;
        end
        if (s - r * r > r)
            r++;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    // Predictor: apply one point, or return the reading for a query.
    task automatic predict_item(input logic kind, input logic nf, input logic [63:0] d);
        longint x, y, z, s;
        int hs, vs, b, p;
        logic [15:0] rng_mm;
        longint unsigned sum;
        bin_reading_t rd;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        z = longint'($signed(d[47:32]));
        if (kind == pdhb_pkg::KIND_POINT)
        begin
            if (nf)
                foreach (bin_fill[i]) bin_fill[i] = 0;
            hs = sector_of(angle_of(x, z), h_fov, h_spr);
            vs = sector_of(angle_of(y, z), v_fov, v_spr);
            if (hs < 0 || vs < 0)
                return;
            s = x * x + y * y + z * z;
            rng_mm = range_of(s);
            b = hs * NSECT + vs;
            p = bin_fill[b];
            if (p >= KEEP)
            begin
                if (rng_mm >= bin_dist[b][KEEP-1])
                    return;
                p = KEEP - 1;
            end
            while (p > 0 && bin_dist[b][p-1] > rng_mm)
            begin
                bin_dist[b][p] = bin_dist[b][p-1];
                p--;
            end
            bin_dist[b][p] = rng_mm;
            if (bin_fill[b] < KEEP)
                bin_fill[b]++;
        end
        else
        begin
            rd = '{16'hFFFF, 1'b1, 5'd0};
            if (d[53:48] < NSECT && d[59:54] < NSECT)
            begin
                b = d[53:48] * NSECT + d[59:54];
                if (bin_fill[b] > 0)
                begin
                    sum = 0;
                    for (int i = 0; i < bin_fill[b]; i++)
                        sum += bin_dist[b][i];
                    rd.mean_mm = 16'((sum + bin_fill[b] / 2) / bin_fill[b]);
                    rd.empty = 1'b0;
                    rd.used = 5'(bin_fill[b]);
                end
            end
            expected_readings.insert(expected_readings.size(), rd);
        end
    endtask

    // Send one item; the prediction is made when it is accepted.
    task automatic send_item(input logic kind, input logic nf, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z,
                             input logic [5:0] qh, input logic [5:0] qv);
        logic [63:0] d;
        d = {4'd0, qv, qh, z, y, x};
        @(negedge clk);
        while (idle_enable && $urandom_range(99) < 27)
            @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= {nf, kind};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(kind, nf, d);
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_point(input logic nf, input int x, input int y, input int z);
        send_item(pdhb_pkg::KIND_POINT, nf, x[15:0], y[15:0], z[15:0],
                  6'($urandom), 6'($urandom));
    endtask

    task automatic send_query(input int qh, input int qv);
        send_item(pdhb_pkg::KIND_QUERY, 1'($urandom_range(1)), 16'($urandom),
                  16'($urandom), 16'($urandom), qh[5:0], qv[5:0]);
    endtask

    // Wait for all readings, then the worst point latency, before a register write.
    task automatic drain_block();
        while (expected_readings.size() != 0)
            @(negedge clk);
        repeat (NBINS + 200) @(negedge clk);
    endtask

    task automatic write_register(input pdhb_pkg::cfg_index_t idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pdhb_pkg::CFG_H_FOV: h_fov = val[17:0];
            pdhb_pkg::CFG_V_FOV: v_fov = val[17:0];
            pdhb_pkg::CFG_H_SPR: h_spr = val;
            default:             v_spr = val;
        endcase
        @(negedge clk);
    endtask

    // A point whose coordinates tend to fall inside the view.
    task automatic random_point(input logic nf);
        int z;
        z = $urandom_range(40000) < 36000 ? $urandom_range(32767, 100) : $urandom;
        if ($urandom_range(3) == 0)
            send_point(nf, $signed(16'($urandom)), $signed(16'($urandom)),
                       $signed(16'($urandom)));
        else
            send_point(nf, $signed(16'(int'($urandom_range(2 * z / 3)) - z / 3)),
                       $signed(16'(int'($urandom_range(z / 2)) - z / 4)), z);
    endtask

    task automatic test_directed();
        send_point(1'b1, 0, 0, 0);
        send_point(1'b0, 0, 0, 1000);
        send_point(1'b0, 0, 0, 1000);
        send_point(1'b0, 100, 50, 2000);
        send_point(1'b0, -32768, -32768, -32768);
        send_point(1'b0, 32767, 32767, 32767);
        send_point(1'b0, 32767, 0, 32767);
        send_point(1'b0, 0, 0, -5000);
        send_point(1'b0, 0, 1, 0);
        send_point(1'b0, 0, 0, 32767);
        send_query(22, 22);
        send_query(0, 0);
        send_query(44, 44);
        send_query(45, 10);
        send_query(10, 63);
        send_query(63, 63);
        // Fill one bin past its capacity with decreasing then equal ranges.
        for (int i = 0; i < 12; i++)
            send_point(1'b0, 0, 0, 3000 - 100 * i);
        send_point(1'b0, 0, 0, 1900);
        send_query(22, 22);
        // A rejected point with a frame clear still empties the bins.
        send_point(1'b1, 0, 0, -100);
        send_query(22, 22);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 3)
                send_query($urandom_range(9) == 0 ? $urandom_range(63) :
                           $urandom_range(17, 27), $urandom_range(9) == 0 ?
                           $urandom_range(63) : $urandom_range(17, 27));
            else
                random_point($urandom_range(60) == 0);
        end
    endtask

    // Pause until every reading has come back, then go on.
    task automatic test_pause();
        while (expected_readings.size() != 0)
            @(negedge clk);
        send_query(22, 22);
    endtask

    task automatic test_settings();
        logic [23:0] h_list[4] = '{24'd0, 24'd205887, 24'd98368, 24'd150000};
        logic [23:0] v_list[4] = '{24'd205887, 24'd0, 24'd53462, 24'd80000};
        logic [23:0] hs_list[4] = '{24'd1000000, 24'hFFFFFF, 24'd0, 24'd1300000};
        logic [23:0] vs_list[4] = '{24'hFFFFFF, 24'd900000, 24'd3615164, 24'd0};
        for (int k = 0; k < 4; k++)
        begin
            drain_block();
            write_register(pdhb_pkg::CFG_H_FOV, h_list[k]);
            write_register(pdhb_pkg::CFG_V_FOV, v_list[k]);
            write_register(pdhb_pkg::CFG_H_SPR, hs_list[k]);
            write_register(pdhb_pkg::CFG_V_SPR, vs_list[k]);
            random_point(1'b1);
            test_random(60);
        end
        drain_block();
        write_register(pdhb_pkg::CFG_H_FOV, 24'(pdhb_pkg::RESET_H_FOV));
        write_register(pdhb_pkg::CFG_V_FOV, 24'(pdhb_pkg::RESET_V_FOV));
        write_register(pdhb_pkg::CFG_H_SPR, pdhb_pkg::RESET_H_SPR);
        write_register(pdhb_pkg::CFG_V_SPR, pdhb_pkg::RESET_V_SPR);
    endtask

    // Check every reading against the oldest expectation.
    always @(posedge clk)
    begin
        bin_reading_t exp_rd;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected reading %h empty %b", $time, m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                exp_rd = expected_readings.pop_front();
                if (m_tdata[15:0] !== exp_rd.mean_mm)
                begin
                    $display("%0t: mean expected %0d actual %0d", $time, exp_rd.mean_mm,
                             m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[20:16] !== exp_rd.used)
                begin
                    $display("%0t: samples expected %0d actual %0d", $time, exp_rd.used,
                             m_tdata[20:16]);
                    error_count++;
                end
                if (m_tuser !== exp_rd.empty)
                begin
                    $display("%0t: empty expected %b actual %b", $time, exp_rd.empty,
                             m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Result-side stalls.
    always @(negedge clk)
        m_tready <= !idle_enable || ($urandom_range(99) >= 27);

    // Run limit.
    initial
    begin
        #60000000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        error_count = 0;
        results_seen = 0;
        idle_enable = 1'b1;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        cfg_we = 1'b0; cfg_index = pdhb_pkg::CFG_H_FOV; cfg_data = '0;
        h_fov = pdhb_pkg::RESET_H_FOV; v_fov = pdhb_pkg::RESET_V_FOV;
        h_spr = pdhb_pkg::RESET_H_SPR; v_spr = pdhb_pkg::RESET_V_SPR;
        foreach (bin_fill[i]) bin_fill[i] = 0;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_pause();
        test_settings();
        test_random(400);
        idle_enable = 1'b0;
        test_random(200);
        idle_enable = 1'b1;
        test_random(420);
        while (expected_readings.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pdhb_pkg.sv
rtl/pdhb_cordic.sv
rtl/polar_depth_histogram_builder.sv
rtl/pdhb_checker.sv
dv/tb.sv
